FILE: rtl/rls_parameter_estimator_unit_defines.svh
// Assertion macros for the RLS parameter estimator.
// Used by rls_parameter_estimator_unit; expects clk and rst_n in scope.
`ifndef RLS_PARAMETER_ESTIMATOR_UNIT_DEFINES_SVH
`define RLS_PARAMETER_ESTIMATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RLS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rls estimator check failed");

// Next-cycle implication.
`define RLS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rls estimator check failed");

`endif

FILE: rtl/rls_pkg.sv
// Shared types, constants and fixed-point helpers of the RLS estimator.
// No dependencies.
package rls_pkg;

    localparam int MAX_SIZE = 4;
    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int CELLS    = MAX_SIZE * MAX_SIZE;
    localparam int CNT_W    = $clog2(2 * CELLS);
    localparam int DIVD_W   = 66;
    localparam int DIVS_W   = 51;
    localparam int Q_W      = 32;

    localparam logic [16:0] LAMBDA_MIN = 17'd32768;
    localparam logic [16:0] LAMBDA_MAX = 17'd65536;

    localparam logic [1:0] CFG_FORGET    = 2'd0;
    localparam logic [1:0] CFG_COV_SCALE = 2'd1;
    localparam logic [1:0] CFG_ACTIVE    = 2'd2;

    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

    typedef enum logic [1:0] {
        OP_UPDATE,
        OP_RESET,
        OP_LOAD,
        OP_NOP
    } opcode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_V_MUL,
        S_V_ACC,
        S_S_MUL,
        S_S_ACC,
        S_DEN,
        S_K_DIV_START,
        S_K_DIV_WAIT,
        S_K_MUL,
        S_K_ACC,
        S_P_MUL,
        S_P_DIV_START,
        S_P_DIV_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_status_t;

    function automatic logic signed [47:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return signed'(p[63:16]);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = 32'sh7fffffff;
        else if (v < S32_MIN)
            r = 32'sh80000000;
        else
            r = signed'(v[31:0]);
        return r;
    endfunction

    function automatic logic ovf32(input logic signed [65:0] v);
        return (v > S32_MAX) || (v < S32_MIN);
    endfunction

endpackage

FILE: rtl/rls_div.sv
// Restoring signed divider, one quotient bit per cycle, saturating to 32 bits.
// Depends on rls_pkg.
module rls_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [rls_pkg::DIVD_W-1:0] dividend,
    input  logic        [rls_pkg::DIVS_W-1:0] divisor,
    output logic signed [rls_pkg::Q_W-1:0]   quotient,
    output rls_pkg::div_status_t             status
);
    import rls_pkg::*;

    localparam int DS_W = DIVS_W + Q_W - 1;

    logic                busy_reg;
    logic                done_reg;
    logic [4:0]          cnt_reg;
    logic [DIVD_W-1:0]   rem_reg;
    logic [DS_W-1:0]     ds_reg;
    logic [Q_W-1:0]      q_reg;
    logic                neg_reg;
    logic                big_reg;

    logic [DIVD_W-1:0]   mag;
    logic                big;
    logic                ge;

    assign mag = dividend[DIVD_W-1] ? DIVD_W'(-dividend) : DIVD_W'(dividend);
    assign big = {{(DIVS_W + Q_W - DIVD_W){1'b0}}, mag} >= {divisor, {Q_W{1'b0}}};
    assign ge  = {{(DS_W - DIVD_W){1'b0}}, rem_reg} >= ds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(Q_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= mag;
            ds_reg  <= {divisor, {(Q_W - 1){1'b0}}};
            q_reg   <= '0;
            neg_reg <= dividend[DIVD_W-1];
            big_reg <= big;
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_reg <= rem_reg - ds_reg[DIVD_W-1:0];
            q_reg  <= {q_reg[Q_W-2:0], ge};
            ds_reg <= ds_reg >> 1;
        end
    end

    always_comb
    begin
        status.done = done_reg;
        status.ovf  = 1'b0;
        quotient    = signed'(q_reg);
        if (big_reg)
        begin
            status.ovf = 1'b1;
            quotient   = neg_reg ? 32'sh80000000 : 32'sh7fffffff;
        end
        else if (!neg_reg)
        begin
            if (q_reg[Q_W-1])
            begin
                status.ovf = 1'b1;
                quotient   = 32'sh7fffffff;
            end
        end
        else if (q_reg > 32'h80000000)
        begin
            status.ovf = 1'b1;
            quotient   = 32'sh80000000;
        end
        else
            quotient = signed'(-q_reg);
    end

endmodule

FILE: rtl/rls_parameter_estimator_unit.sv
// Top level of the RLS estimator: sequencer, shared multiplier, state storage.
// Depends on rls_pkg, rls_div and rls_parameter_estimator_unit_defines.svh.
//
// Usage:
//   Input channel in_valid/in_stall carries opcode, x0..x3 and measured; a
//   transfer happens when in_valid is high and in_stall is low. Output channel
//   out_valid/out_stall carries est0..est3, prior_error and saturated, one
//   result per input item. Configuration is written through cfg_write,
//   cfg_index and cfg_data; the user must write it only while the block is
//   idle, as the block itself does not enforce this.
//   Reset, load and no-op items pass from their transfer through the done
//   state into the output register. An update takes 40 products through the
//   one shared multiplier, 4 gain steps and 16 covariance steps, each a pass
//   through the shared 32-step restoring divider plus its product, and a
//   denominator step before the output load.
//   The block takes one item at a time and holds in_stall high meanwhile.
//   Reset puts the covariance at the reset diagonal, zeroes the estimates and
//   loads register defaults; no clearing pass is needed.
//   When the receiver stalls, the result holds in the output register; the
//   block may take the next item, and finishes it but holds it until the
//   output register frees up.
`include "rls_parameter_estimator_unit_defines.svh"
module rls_parameter_estimator_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] x0,
    input  logic signed [31:0] x1,
    input  logic signed [31:0] x2,
    input  logic signed [31:0] x3,
    input  logic signed [31:0] measured,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] est0,
    output logic signed [31:0] est1,
    output logic signed [31:0] est2,
    output logic signed [31:0] est3,
    output logic signed [31:0] prior_error,
    output logic               saturated
);
    import rls_pkg::*;

    localparam logic [CNT_W-1:0] V_LAST = CNT_W'(2 * CELLS - 1);
    localparam logic [CNT_W-1:0] S_LAST = CNT_W'(2 * MAX_SIZE - 1);
    localparam logic [CNT_W-1:0] P_LAST = CNT_W'(CELLS - 1);
    localparam logic [IDX_W-1:0] I_LAST = IDX_W'(MAX_SIZE - 1);

    state_t state_reg, state_next;

    logic [16:0]  forget_factor_reg;
    logic [30:0]  init_cov_scale_reg;
    logic [2:0]   active_size_reg;

    logic [CNT_W-1:0]  cnt_reg;
    logic signed [31:0] x_reg     [MAX_SIZE];
    logic signed [31:0] y_reg;
    opcode_t            op_reg;
    logic signed [31:0] cov_reg   [CELLS];
    logic signed [31:0] theta_reg [MAX_SIZE];
    logic signed [31:0] v_reg     [MAX_SIZE];
    logic signed [31:0] w_reg     [MAX_SIZE];
    logic signed [31:0] k_reg     [MAX_SIZE];
    logic signed [51:0] acc_a_reg;
    logic signed [51:0] acc_b_reg;
    logic signed [47:0] prod_reg;
    logic [DIVS_W-1:0]  den_reg;
    logic signed [31:0] e_reg;
    logic               clip_reg;

    logic signed [31:0] xin [MAX_SIZE];
    logic [2:0]         n_use;
    logic [16:0]        lam;
    logic [IDX_W-1:0]   row, col;
    logic               sel;
    logic [IDX_W*2-1:0] cov_addr;
    logic signed [31:0] cov_rd;
    logic signed [31:0] mul_a, mul_b;
    logic signed [51:0] prod_ext;
    logic signed [51:0] w_sum;
    logic signed [51:0] den_full;
    logic signed [65:0] err_full;
    logic signed [48:0] cov_diff;
    logic signed [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0]  div_divisor;
    logic signed [31:0] div_q;
    div_status_t        div_stat;
    logic               div_start;
    logic               out_load;
    logic               accept;

    assign xin[0] = x0;
    assign xin[1] = x1;
    assign xin[2] = x2;
    assign xin[3] = x3;

    assign n_use  = (active_size_reg > 3'(MAX_SIZE)) ? 3'(MAX_SIZE) : active_size_reg;
    assign lam    = (forget_factor_reg < LAMBDA_MIN) ? LAMBDA_MIN :
                    (forget_factor_reg > LAMBDA_MAX) ? LAMBDA_MAX : forget_factor_reg;
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        row = '0;
        col = '0;
        sel = 1'b0;
        case (state_reg)
            S_V_MUL, S_V_ACC:
            begin
                row = cnt_reg[4:3];
                col = cnt_reg[2:1];
                sel = cnt_reg[0];
            end
            S_S_MUL, S_S_ACC:
            begin
                row = cnt_reg[2:1];
                sel = cnt_reg[0];
            end
            S_K_DIV_START, S_K_DIV_WAIT, S_K_MUL, S_K_ACC:
                row = cnt_reg[1:0];
            S_P_MUL, S_P_DIV_START, S_P_DIV_WAIT:
            begin
                row = cnt_reg[3:2];
                col = cnt_reg[1:0];
            end
            default:
                row = '0;
        endcase
    end

    assign cov_addr = (state_reg inside {S_V_MUL, S_V_ACC} && sel) ? {col, row} : {row, col};
    assign cov_rd   = cov_reg[cov_addr];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_V_MUL:
            begin
                mul_a = cov_rd;
                mul_b = x_reg[col];
            end
            S_S_MUL:
            begin
                mul_a = x_reg[row];
                mul_b = sel ? theta_reg[row] : v_reg[row];
            end
            S_K_MUL:
            begin
                mul_a = k_reg[row];
                mul_b = e_reg;
            end
            S_P_MUL:
            begin
                mul_a = k_reg[row];
                mul_b = w_reg[col];
            end
            default:
                mul_a = '0;
        endcase
    end

    assign prod_ext = {{4{prod_reg[47]}}, prod_reg};
    assign w_sum    = acc_b_reg + prod_ext;
    assign den_full = signed'({35'b0, lam}) + acc_a_reg;
    assign err_full = {{34{y_reg[31]}}, y_reg} - {{14{acc_b_reg[51]}}, acc_b_reg};
    assign cov_diff = {{17{cov_rd[31]}}, cov_rd} - {prod_reg[47], prod_reg};

    always_comb
    begin
        if (state_reg == S_P_DIV_START)
        begin
            div_dividend = {cov_diff[48], cov_diff, 16'b0};
            div_divisor  = {34'b0, lam};
        end
        else
        begin
            div_dividend = {{18{v_reg[row][31]}}, v_reg[row], 16'b0};
            div_divisor  = den_reg;
        end
    end

    rls_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .status   (div_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = (opcode_t'(opcode) == OP_UPDATE) ? S_V_MUL : S_DONE;
            S_V_MUL:       state_next = S_V_ACC;
            S_V_ACC:       state_next = (cnt_reg == V_LAST) ? S_S_MUL : S_V_MUL;
            S_S_MUL:       state_next = S_S_ACC;
            S_S_ACC:       state_next = (cnt_reg == S_LAST) ? S_DEN : S_S_MUL;
            S_DEN:         state_next = S_K_DIV_START;
            S_K_DIV_START: state_next = S_K_DIV_WAIT;
            S_K_DIV_WAIT:
                if (div_stat.done)
                    state_next = S_K_MUL;
            S_K_MUL:       state_next = S_K_ACC;
            S_K_ACC:       state_next = (row == I_LAST) ? S_P_MUL : S_K_DIV_START;
            S_P_MUL:       state_next = S_P_DIV_START;
            S_P_DIV_START: state_next = S_P_DIV_WAIT;
            S_P_DIV_WAIT:
                if (div_stat.done)
                    state_next = (cnt_reg == P_LAST) ? S_DONE : S_P_MUL;
            S_DONE:
                if (!out_valid || !out_stall)
                    state_next = S_IDLE;
            default:       state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        div_start = (state_reg == S_K_DIV_START) || (state_reg == S_P_DIV_START);
        out_load  = (state_reg == S_DONE) && (!out_valid || !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forget_factor_reg  <= 17'd65536;
            init_cov_scale_reg <= 31'd6553600;
            active_size_reg    <= 3'd4;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FORGET:    forget_factor_reg  <= cfg_data[16:0];
                CFG_COV_SCALE: init_cov_scale_reg <= cfg_data;
                CFG_ACTIVE:    active_size_reg    <= cfg_data[2:0];
                default:       active_size_reg    <= active_size_reg;
            endcase
        end
    end

    // State, counter and flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            clip_reg  <= 1'b0;
            out_valid <= 1'b0;
            for (int i = 0; i < CELLS; i++)
                cov_reg[i] <= (i % (MAX_SIZE + 1) == 0) ? 32'sd6553600 : 32'sd0;
            for (int i = 0; i < MAX_SIZE; i++)
                theta_reg[i] <= '0;
        end
        else
        begin
            if (out_load)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;

            case (state_reg)
                S_IDLE:
                    if (accept)
                    begin
                        cnt_reg  <= '0;
                        clip_reg <= 1'b0;
                        if (opcode_t'(opcode) == OP_RESET)
                        begin
                            for (int i = 0; i < CELLS; i++)
                                cov_reg[i] <= (i % (MAX_SIZE + 1) == 0) ?
                                              signed'({1'b0, init_cov_scale_reg}) : 32'sd0;
                            for (int i = 0; i < MAX_SIZE; i++)
                                theta_reg[i] <= '0;
                        end
                        else if (opcode_t'(opcode) == OP_LOAD)
                        begin
                            for (int i = 0; i < MAX_SIZE; i++)
                                if (3'(i) < n_use)
                                    theta_reg[i] <= xin[i];
                        end
                    end
                S_V_ACC:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (sel && col == I_LAST)
                        clip_reg <= clip_reg
                                    | ovf32({{14{acc_a_reg[51]}}, acc_a_reg})
                                    | ovf32({{14{w_sum[51]}}, w_sum});
                    if (cnt_reg == V_LAST)
                        cnt_reg <= '0;
                end
                S_S_ACC:
                    cnt_reg <= (cnt_reg == S_LAST) ? '0 : cnt_reg + CNT_W'(1);
                S_DEN:
                    clip_reg <= clip_reg | (den_full < 52'sd1) | ovf32(err_full);
                S_K_DIV_WAIT:
                    if (div_stat.done)
                        clip_reg <= clip_reg | div_stat.ovf;
                S_K_ACC:
                begin
                    theta_reg[row] <= sat32({{34{theta_reg[row][31]}}, theta_reg[row]}
                                            + {{18{prod_reg[47]}}, prod_reg});
                    clip_reg <= clip_reg | ovf32({{34{theta_reg[row][31]}}, theta_reg[row]}
                                                 + {{18{prod_reg[47]}}, prod_reg});
                    cnt_reg <= (row == I_LAST) ? '0 : cnt_reg + CNT_W'(1);
                end
                S_P_DIV_WAIT:
                    if (div_stat.done)
                    begin
                        cov_reg[{row, col}] <= div_q;
                        clip_reg <= clip_reg | div_stat.ovf;
                        cnt_reg  <= cnt_reg + CNT_W'(1);
                    end
                default:
                    cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Datapath payload registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= qmul(mul_a, mul_b);
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    for (int i = 0; i < MAX_SIZE; i++)
                        x_reg[i] <= (3'(i) < n_use) ? xin[i] : 32'sd0;
                    y_reg     <= measured;
                    op_reg    <= opcode_t'(opcode);
                    acc_a_reg <= '0;
                    acc_b_reg <= '0;
                end
            S_V_ACC:
                if (!sel)
                    acc_a_reg <= acc_a_reg + prod_ext;
                else if (col == I_LAST)
                begin
                    v_reg[row] <= sat32({{14{acc_a_reg[51]}}, acc_a_reg});
                    w_reg[row] <= sat32({{14{w_sum[51]}}, w_sum});
                    acc_a_reg  <= '0;
                    acc_b_reg  <= '0;
                end
                else
                    acc_b_reg <= acc_b_reg + prod_ext;
            S_S_ACC:
                if (!sel)
                    acc_a_reg <= acc_a_reg + prod_ext;
                else
                    acc_b_reg <= acc_b_reg + prod_ext;
            S_DEN:
            begin
                den_reg <= (den_full < 52'sd1) ? DIVS_W'(1) : den_full[DIVS_W-1:0];
                e_reg   <= sat32(err_full);
            end
            S_K_DIV_WAIT:
                if (div_stat.done)
                    k_reg[row] <= div_q;
            default:
                y_reg <= y_reg;
        endcase

        if (out_load)
        begin
            est0        <= theta_reg[0];
            est1        <= theta_reg[1];
            est2        <= theta_reg[2];
            est3        <= theta_reg[3];
            prior_error <= (op_reg == OP_UPDATE) ? e_reg : 32'sd0;
            saturated   <= clip_reg;
        end
    end

    `RLS_ASSERT_NXT(a_accept_busy, accept, in_stall)
    `RLS_ASSERT_IMP(a_div_done_wait, div_stat.done,
        (state_reg == S_K_DIV_WAIT) || (state_reg == S_P_DIV_WAIT))
    `RLS_ASSERT_IMP(a_no_clip_non_update, (state_reg == S_DONE) && (op_reg != OP_UPDATE),
        !clip_reg)
    `RLS_ASSERT_IMP(a_den_nonzero, state_reg == S_K_DIV_START, den_reg != '0)

endmodule
